@@ src/chunk_header_parser_assert.svh @@
// Assertion macros for the chunk header parser.
// Used by the top level only; no other dependencies.
`ifndef CHUNK_HEADER_PARSER_ASSERT_SVH
`define CHUNK_HEADER_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CHP_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define CHP_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define CHP_ASSERT_IMPL(label, clk, rst, a, c)
`define CHP_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ src/chp_pkg.sv @@
// Shared types and constants of the chunk header parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package chp_pkg;
  localparam int ENTRIES = 16;
  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [23:0] TS_EXTENDED = 24'hffffff;
  localparam logic [1:0] ST_COMPLETE = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Parsed header as handed from front to back
  typedef struct packed {
    logic        truncated;
    logic [1:0]  fmt;
    logic [16:0] channel;
    logic [31:0] time_val;
    logic [23:0] size;
    logic [7:0]  kind;
    logic [31:0] stream;
    logic [4:0]  nbytes;
  } hdr_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  fmt;
    logic [16:0] channel;
    logic [31:0] time_val;
    logic [23:0] size;
    logic [7:0]  kind;
    logic [31:0] stream;
    logic [4:0]  nbytes;
    logic        had;
  } res_t;

  function automatic logic [4:0] msg_len(input logic [1:0] f);
    unique case (f)
      2'd0: msg_len = 5'd11;
      2'd1: msg_len = 5'd7;
      2'd2: msg_len = 5'd3;
      default: msg_len = 5'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ src/chp_front.sv @@
// Byte assembler: collects header bytes into a parsed header request.
// Depends on chp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    data_byte,
  input  wire logic          header_start,
  input  wire logic          in_valid,
  output logic               in_ready,
  output chp_pkg::hdr_t      hdr,
  output logic               hdr_valid,
  input  wire logic          hdr_ready
);
  import chp_pkg::*;

  logic [4:0] byte_position, needed_bytes, id_len, q;
  logic       assembling;
  hdr_t       part;
  logic [4:0] pos_next, need_next;
  hdr_t       part_next;
  logic       done;
  logic       take, short_hdr, push;
  logic [16:0] start_chan;
  hdr_t       hdr_next;

  assign in_ready = !hdr_valid || hdr_ready;
  assign take = in_valid && in_ready;
  assign start_chan = (data_byte[5:1] == 5'd0) ? 17'd64 : {11'd0, data_byte[5:0]};
  // format 3 with a one-byte id completes on its start byte
  assign short_hdr = (data_byte[7:6] == 2'd3) && (data_byte[5:1] != 5'd0);
  assign id_len = needed_bytes - msg_len(part.fmt) -
                  ((part.fmt == 2'd0 && needed_bytes >= 5'd16) ? 5'd4 : 5'd0);
  assign q = byte_position - id_len;

  // Next-state of the partial header for a non-start byte
  always_comb begin
    part_next = part;
    need_next = needed_bytes;
    pos_next = byte_position + 5'd1;
    if (byte_position < id_len) begin
      if (byte_position == 5'd1) part_next.channel = 17'd64 + {9'd0, data_byte};
      else if (byte_position == 5'd2)
        part_next.channel = part.channel + {1'b0, data_byte, 8'd0};
    end else if (q <= 5'd2) begin
      part_next.time_val = {8'd0, part.time_val[15:0], data_byte};
      if (q == 5'd2 && part.fmt == 2'd0 && {part.time_val[15:0], data_byte} == TS_EXTENDED)
        need_next = needed_bytes + 5'd4;
    end else if (q <= 5'd5) begin
      part_next.size = {part.size[15:0], data_byte};
    end else if (q == 5'd6) begin
      part_next.kind = data_byte;
    end else if (q <= 5'd10) begin
      part_next.stream = part.stream | ({24'd0, data_byte} << {q[1:0] - 2'd3, 3'd0});
    end else if (q == 5'd11) begin
      part_next.time_val = {24'd0, data_byte};
    end else begin
      part_next.time_val = {part.time_val[23:0], data_byte};
    end
    done = pos_next >= need_next;
  end

  // Header handed to the table stage
  always_comb begin
    hdr_next = part_next;
    hdr_next.nbytes = need_next;
    push = 1'b0;
    if (take && header_start) begin
      if (assembling) begin
        hdr_next = part;
        hdr_next.truncated = 1'b1;
        hdr_next.nbytes = byte_position;
        push = 1'b1;
      end else if (short_hdr) begin
        hdr_next = '{1'b0, 2'd3, start_chan, 32'd0, 24'd0, 8'd0, 32'd0, 5'd1};
        push = 1'b1;
      end
    end else if (take && assembling && done) begin
      push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      assembling <= 1'b0;
      hdr_valid <= 1'b0;
      byte_position <= 5'd0;
      needed_bytes <= 5'd0;
    end else begin
      if (push) hdr_valid <= 1'b1;
      else if (hdr_ready) hdr_valid <= 1'b0;
      if (push) hdr <= hdr_next;
      if (take) begin
        if (header_start) begin
          if (assembling) begin
            assembling <= 1'b0;
          end else begin
            part <= '{1'b0, data_byte[7:6], start_chan, 32'd0, 24'd0, 8'd0, 32'd0, 5'd0};
            needed_bytes <= msg_len(data_byte[7:6]) +
              ((data_byte[5:0] == 6'd0) ? 5'd2 : (data_byte[5:0] == 6'd1) ? 5'd3 : 5'd1);
            byte_position <= 5'd1;
            assembling <= !short_hdr;
          end
        end else if (assembling) begin
          part <= part_next;
          needed_bytes <= need_next;
          byte_position <= pos_next;
          if (done) assembling <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ src/chp_back.sv @@
// Table stage: looks up previous headers, resolves and writes back.
// Depends on chp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module chp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  chp_pkg::hdr_t      hdr,
  input  wire logic          hdr_valid,
  output logic               hdr_ready,
  output chp_pkg::res_t      res,
  output logic               res_valid,
  input  wire logic          res_ready
);
  import chp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_OUT} state_t;
  state_t state;

  logic [ENTRIES-1:0] slot_used;
  logic [16:0] slot_channel [ENTRIES];
  logic [95:0] slot_data [ENTRIES];
  logic [95:0] rd;
  hdr_t cur;
  logic [SLOT_W-1:0] idx, hit, fre;
  logic found, got_free;
  logic [31:0] pt, t;
  logic [23:0] ps, s;
  logic [7:0]  pk, k;
  logic [31:0] pm, m;
  logic [1:0]  status;
  logic        last;
  logic        out_fire;

  assign hdr_ready = (state == S_IDLE);
  assign last = ({{(32-SLOT_W){1'b0}}, idx} == ENTRIES - 1);
  assign {pt, ps, pk, pm} = found ? rd : 96'd0;
  assign status = found ? ST_COMPLETE : (got_free ? ST_COMPLETE : ST_FULL);
  assign out_fire = (state == S_OUT) && (!res_valid || res_ready);

  // Field resolution by format
  always_comb begin
    unique case (cur.fmt)
      2'd0: begin t = cur.time_val; s = cur.size; k = cur.kind; m = cur.stream; end
      2'd1: begin t = pt + cur.time_val; s = cur.size; k = cur.kind; m = pm; end
      2'd2: begin t = pt + cur.time_val; s = ps; k = pk; m = pm; end
      default: begin t = pt; s = ps; k = pk; m = pm; end
    endcase
  end

  // Previous-value memory read
  always_ff @(posedge clk) rd <= slot_data[hit];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      slot_used <= '0;
    end else begin
      if (out_fire) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (hdr_valid) begin
          cur <= hdr;
          idx <= '0;
          found <= 1'b0;
          got_free <= 1'b0;
          if (hdr.truncated) begin
            state <= S_OUT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one slot per cycle, first match wins
          if (!found && slot_used[idx] && slot_channel[idx] == cur.channel) begin
            found <= 1'b1;
            hit <= idx;
          end
          if (!got_free && !slot_used[idx]) begin
            got_free <= 1'b1;
            fre <= idx;
          end
          if (last) state <= S_READ;
          else idx <= idx + 1'b1;
        end
        S_READ: state <= S_OUT;
        S_OUT: if (out_fire) begin
          state <= S_IDLE;
          if (cur.truncated) begin
            res <= '{ST_TRUNCATED, cur.fmt, cur.channel, cur.time_val, cur.size,
                     cur.kind, cur.stream, cur.nbytes, 1'b0};
          end else begin
            res <= '{status, cur.fmt, cur.channel, t, s, k, m, cur.nbytes, found};
            if (found || got_free) begin
              slot_used[found ? hit : fre] <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Table write-back
  always_ff @(posedge clk) begin
    if (out_fire && !cur.truncated && (found || got_free)) begin
      slot_channel[found ? hit : fre] <= cur.channel;
      slot_data[found ? hit : fre] <= {t, s, k, m};
    end
  end
endmodule
`default_nettype wire

@@ src/chunk_header_parser.sv @@
// Chunk header parser: a byte assembler front end feeding a table back end.
// Depends on chp_pkg, chp_front, chp_back and chunk_header_parser_assert.svh.
//
// Usage:
//   s_axis carries header bytes, one per request; tuser marks the first byte
//   of each header. m_axis carries one resolved header per completed or
//   truncated header. Bytes are taken one per cycle while the one-entry
//   queue toward the table stage is free. Closing a header takes it from the
//   queue, scans all ENTRIES slots of the table, reads the previous values
//   and then outputs the result; the front keeps assembling the next header
//   meanwhile, so for short headers the scan of the slot table sets the pace.
//   Truncation reports skip the scan and the read and go straight to output.
//   Reset empties the table (all slots free) and drops any partial header.
//   When m_axis stalls, the result register holds and the back end waits;
//   the front keeps taking bytes until its queue entry is full.
`timescale 1ns / 1ps
`default_nettype none
`include "chunk_header_parser_assert.svh"
module chunk_header_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,   // data_byte
  input  wire logic          s_axis_tuser,   // header_start
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // status[1:0], header_format[3:2], stream_channel[20:4], time_value[52:21],
  // message_size[76:53], message_kind[84:77], message_stream[116:85],
  // header_bytes[121:117], had_previous[122], zero fill up to 127
  output logic [127:0]       m_axis_tdata
);
  import chp_pkg::*;

  hdr_t hdr;
  logic hdr_valid, hdr_ready;
  res_t res;

  chp_front u_front (
    .clk, .rst, .data_byte(s_axis_tdata), .header_start(s_axis_tuser),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .hdr, .hdr_valid, .hdr_ready
  );

  chp_back u_back (
    .clk, .rst, .hdr, .hdr_valid, .hdr_ready,
    .res, .res_valid(m_axis_tvalid), .res_ready(m_axis_tready)
  );

  assign m_axis_tdata = {5'd0, res.had, res.nbytes, res.stream, res.kind, res.size,
                         res.time_val, res.channel, res.fmt, res.status};

  `CHP_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CHP_ASSERT_IMPL(a_status, clk, rst, m_axis_tvalid, res.status != 2'd3)
  `CHP_ASSERT_IMPL(a_trunc, clk, rst, m_axis_tvalid && res.status == ST_TRUNCATED, !res.had)
endmodule
`default_nettype wire
